>>> design/rmq_pkg.sv
// Shared types, constants and helpers for the rotation-matrix-to-quaternion block.
// No dependencies.
package rmq_pkg;

  localparam int DATA_W        = 16;  // width of every matrix element and component
  localparam int FRAC_BITS_DEF = 14;  // default fraction bits (Q2.14)
  localparam int QUO_W         = 17;  // quotient bits kept ahead of saturation
  localparam int LANES         = 3;   // divided components per item

  typedef enum logic [1:0] {
    SEL_TRACE = 2'd0,
    SEL_X     = 2'd1,
    SEL_Y     = 2'd2,
    SEL_Z     = 2'd3
  } sel_t;

  // Saturate a sign-magnitude quotient to a signed 16-bit component.
  function automatic logic [DATA_W-1:0] sat_quo(input logic [QUO_W-1:0] q,
                                                input logic ovf, input logic neg);
    logic [QUO_W-1:0] qn;
    qn = -q;
    if (!neg) begin
      if (ovf || q > QUO_W'(32767)) sat_quo = 16'h7fff;
      else sat_quo = q[DATA_W-1:0];
    end else begin
      if (ovf || q > QUO_W'(32768)) sat_quo = 16'h8000;
      else sat_quo = qn[DATA_W-1:0];
    end
  endfunction

endpackage

>>> design/rmq_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per cycle while en is high.
// Depends on rmq_pkg.
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [QW+1:0]   rem_i,
  input  logic [QW-1:0]   root_i,
  input  logic [2*QW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [QW+1:0]   rem_o,
  output logic [QW-1:0]   root_o,
  output logic [2*QW-1:0] rad_o,
  output logic [SW-1:0]   side_o
);

  logic [QW+1:0] rem_t, trial;
  logic          take;
  logic          vld_r;
  logic [QW+1:0]   rem_r, rem_nxt;
  logic [QW-1:0]   root_r, root_nxt;
  logic [2*QW-1:0] rad_r;
  logic [SW-1:0]   side_r;

  always_comb begin
    rem_t = {rem_i[QW-1:0], rad_i[2*QW-1 -: 2]};
    trial = {root_i, 2'b01};
    take  = (rem_t >= trial);
    rem_nxt  = take ? (rem_t - trial) : rem_t;
    root_nxt = {root_i[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_i << 2;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign side_o = side_r;

endmodule

>>> design/rmq_div_cell.sv
// One cell of the divider chain: one quotient bit per lane per cycle while en is high.
// Depends on rmq_pkg.
module rmq_div_cell import rmq_pkg::*; #(
  parameter int DW = 17,
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [DW-1:0]               dvs_i,
  input  logic [LANES-1:0][DW-1:0]    rem_i,
  input  logic [LANES-1:0][QUO_W-1:0] lo_i,
  input  logic [SW-1:0]               side_i,
  output logic                        vld_o,
  output logic [DW-1:0]               dvs_o,
  output logic [LANES-1:0][DW-1:0]    rem_o,
  output logic [LANES-1:0][QUO_W-1:0] lo_o,
  output logic [SW-1:0]               side_o
);

  logic                        vld_r;
  logic [DW-1:0]               dvs_r;
  logic [LANES-1:0][DW-1:0]    rem_r, rem_nxt;
  logic [LANES-1:0][QUO_W-1:0] lo_r, lo_nxt;
  logic [SW-1:0]               side_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [DW:0] rem_t, diff;
      logic        take;
      rem_t = {rem_i[l], lo_i[l][QUO_W-1]};
      diff  = rem_t - {1'b0, dvs_i};
      take  = (rem_t >= {1'b0, dvs_i});
      rem_nxt[l] = take ? diff[DW-1:0] : rem_t[DW-1:0];
      lo_nxt[l]  = {lo_i[l][QUO_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r  <= dvs_i;
      rem_r  <= rem_nxt;
      lo_r   <= lo_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign dvs_o  = dvs_r;
  assign rem_o  = rem_r;
  assign lo_o   = lo_r;
  assign side_o = side_r;

endmodule

>>> design/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion (Shepperd's method), Q2.14 by default.
// Depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
//
// Accepts one 3x3 matrix word per cycle and returns one quaternion word per
// matrix, in order. A word passes a front register, a square-root cell per
// root bit, a divider cell per quotient bit and an output register; the
// sustained rate is one word per cycle while the output is not stalled, as
// each cell retires one root bit or one quotient bit per cycle. A stalled
// output holds the whole chain. A radicand that is not positive raises
// out_tuser and zeros the components; components saturate to the 16-bit range.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
  input  logic [143:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // qw, qx, qy, qz (16 bits each, lowest first)
  output logic [63:0]   out_tdata,
  // invalid
  output logic          out_tuser
);

  // radicand width, root width, divisor width
  localparam int RW  = (FRAC_BITS > 16) ? FRAC_BITS + 2 : 18;
  localparam int QW  = (RW + FRAC_BITS + 1) / 2;
  localparam int DW  = QW + 1;
  localparam int DDW = QUO_W + FRAC_BITS;
  localparam int SQ_SW = 2 + 1 + LANES + LANES * QUO_W;
  localparam int DV_SW = 2 + 1 + LANES + LANES + (QW - 1);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- front stage: pick the case, form radicand and numerators
  logic signed [DATA_W-1:0] m [9];
  always_comb for (int i = 0; i < 9; i++) m[i] = in_tdata[i*DATA_W +: DATA_W];

  logic signed [RW:0]      r, one_s, e00, e11, e22;
  logic signed [DATA_W+1:0] tr;
  sel_t                    sel;
  logic signed [QUO_W-1:0] num [LANES];
  logic [LANES-1:0]        neg_c;
  logic [LANES*QUO_W-1:0]  mag_c;

  function automatic logic signed [QUO_W-1:0] sx(input logic signed [DATA_W-1:0] v);
    sx = QUO_W'(v);
  endfunction

  always_comb begin
    one_s = (RW+1)'(1) <<< FRAC_BITS;
    e00 = (RW+1)'(m[0]);
    e11 = (RW+1)'(m[4]);
    e22 = (RW+1)'(m[8]);
    tr  = (DATA_W+2)'(m[0]) + (DATA_W+2)'(m[4]) + (DATA_W+2)'(m[8]);
    if (tr > 0) begin
      sel = SEL_TRACE;
      r   = one_s + e00 + e11 + e22;
      num[0] = sx(m[7]) - sx(m[5]);
      num[1] = sx(m[2]) - sx(m[6]);
      num[2] = sx(m[3]) - sx(m[1]);
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      sel = SEL_X;
      r   = one_s + e00 - e11 - e22;
      num[0] = sx(m[7]) - sx(m[5]);
      num[1] = sx(m[1]) + sx(m[3]);
      num[2] = sx(m[2]) + sx(m[6]);
    end else if (m[4] > m[8]) begin
      sel = SEL_Y;
      r   = one_s + e11 - e00 - e22;
      num[0] = sx(m[2]) - sx(m[6]);
      num[1] = sx(m[1]) + sx(m[3]);
      num[2] = sx(m[5]) + sx(m[7]);
    end else begin
      sel = SEL_Z;
      r   = one_s + e22 - e00 - e11;
      num[0] = sx(m[3]) - sx(m[1]);
      num[1] = sx(m[2]) + sx(m[6]);
      num[2] = sx(m[5]) + sx(m[7]);
    end
    for (int l = 0; l < LANES; l++) begin
      neg_c[l] = num[l][QUO_W-1];
      mag_c[l*QUO_W +: QUO_W] = neg_c[l] ? QUO_W'(-num[l]) : QUO_W'(num[l]);
    end
  end

  logic              f_vld_r;
  logic [RW-1:0]     f_rad_r;
  logic [SQ_SW-1:0]  f_side_r;
  logic              inv_c;
  assign inv_c = (r <= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_rad_r  <= inv_c ? '0 : r[RW-1:0];
      f_side_r <= {mag_c, neg_c, inv_c, sel};
    end
  end

  // ---------------- square-root chain: one root bit per cell
  logic              sq_vld  [QW+1];
  logic [QW+1:0]     sq_rem  [QW+1];
  logic [QW-1:0]     sq_root [QW+1];
  logic [2*QW-1:0]   sq_rad  [QW+1];
  logic [SQ_SW-1:0]  sq_side [QW+1];

  assign sq_vld[0]  = f_vld_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = (2*QW)'(f_rad_r) << FRAC_BITS;
  assign sq_side[0] = f_side_r;

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    rmq_sqrt_cell #(.QW(QW), .SW(SQ_SW)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(sq_vld[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]),
      .rad_i(sq_rad[k]), .side_i(sq_side[k]),
      .vld_o(sq_vld[k+1]), .rem_o(sq_rem[k+1]), .root_o(sq_root[k+1]),
      .rad_o(sq_rad[k+1]), .side_o(sq_side[k+1])
    );
  end

  // ---------------- divider set-up: s = 2*root, split each dividend
  logic [SQ_SW-1:0]             sq_end;
  logic [DW-1:0]                dvs0;
  logic [LANES-1:0][DW-1:0]     rem0;
  logic [LANES-1:0][QUO_W-1:0]  lo0;
  logic [LANES-1:0]             ovf0;
  logic [DV_SW-1:0]             dv_side0;

  assign sq_end = sq_side[QW];
  assign dvs0   = {sq_root[QW], 1'b0};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [DDW-1:0] dd;
      logic [DW-1:0]  hi;
      dd = DDW'(sq_end[3 + LANES + l*QUO_W +: QUO_W]) << FRAC_BITS;
      hi = DW'(dd[DDW-1:QUO_W]);
      ovf0[l] = (hi >= dvs0);
      rem0[l] = hi;
      lo0[l]  = dd[QUO_W-1:0];
    end
    dv_side0 = {sq_root[QW][QW-1:1], ovf0, sq_end[2 + LANES:0]};
  end

  // ---------------- divider chain: one quotient bit per cell per lane
  logic                         dv_vld  [QUO_W+1];
  logic [DW-1:0]                dv_dvs  [QUO_W+1];
  logic [LANES-1:0][DW-1:0]     dv_rem  [QUO_W+1];
  logic [LANES-1:0][QUO_W-1:0]  dv_lo   [QUO_W+1];
  logic [DV_SW-1:0]             dv_side [QUO_W+1];

  assign dv_vld[0]  = sq_vld[QW];
  assign dv_dvs[0]  = dvs0;
  assign dv_rem[0]  = rem0;
  assign dv_lo[0]   = lo0;
  assign dv_side[0] = dv_side0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    rmq_div_cell #(.DW(DW), .SW(DV_SW)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(dv_vld[k]), .dvs_i(dv_dvs[k]), .rem_i(dv_rem[k]),
      .lo_i(dv_lo[k]), .side_i(dv_side[k]),
      .vld_o(dv_vld[k+1]), .dvs_o(dv_dvs[k+1]), .rem_o(dv_rem[k+1]),
      .lo_o(dv_lo[k+1]), .side_o(dv_side[k+1])
    );
  end

  // ---------------- output stage: saturate and place by case
  logic [DV_SW-1:0]   dv_end;
  sel_t               sel_o;
  logic               inv_o;
  logic [LANES-1:0]   neg_o, ovf_o;
  logic [QW-2:0]      quarter;
  logic [DATA_W-1:0]  qs, l0, l1, l2;
  logic [63:0]        data_nxt;

  always_comb begin
    dv_end  = dv_side[QUO_W];
    sel_o   = sel_t'(dv_end[1:0]);
    inv_o   = dv_end[2];
    neg_o   = dv_end[3 +: LANES];
    ovf_o   = dv_end[3 + LANES +: LANES];
    quarter = dv_end[3 + 2*LANES +: QW-1];
    qs = (32'(quarter) > 32'd32767) ? 16'h7fff : DATA_W'(quarter);
    l0 = sat_quo(dv_lo[QUO_W][0], ovf_o[0], neg_o[0]);
    l1 = sat_quo(dv_lo[QUO_W][1], ovf_o[1], neg_o[1]);
    l2 = sat_quo(dv_lo[QUO_W][2], ovf_o[2], neg_o[2]);
    case (sel_o)
      SEL_TRACE: data_nxt = {l2, l1, l0, qs};
      SEL_X:     data_nxt = {l2, l1, qs, l0};
      SEL_Y:     data_nxt = {l2, qs, l1, l0};
      SEL_Z:     data_nxt = {qs, l2, l1, l0};
      default:   data_nxt = '0;
    endcase
    if (inv_o) data_nxt = '0;
  end

  logic        out_vld_r;
  logic [63:0] out_data_r;
  logic        out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= data_nxt;
      out_inv_r  <= inv_o;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_inv_r;

endmodule

>>> design/rmq_checker.sv
// Port-level checks for rotation_matrix_to_quaternion, bound to the top level.
// Depends on rotation_matrix_to_quaternion.
module rmq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic         out_tuser
);

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // invalid words carry zero components
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("invalid word with nonzero components");

  // accept input whenever the output register can advance
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stage");

  // drop the result valid out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

>>> verif/tb_rotation_matrix_to_quaternion.sv
// Testbench for rotation_matrix_to_quaternion: drives matrix words, predicts each
// quaternion word and checks it in order. Depends on rmq_pkg and the block's RTL.
`timescale 1ns / 100ps

class quat_scoreboard;
  typedef struct packed {
    logic [15:0] qz, qy, qx, qw;
    logic        bad;
  } quat_t;

  quat_t pending[$];
  int    errors;
  int    reported;

  static function automatic longint isqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = longint'(1) <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  static function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  static function automatic longint quo(longint num, longint s);
    if (s <= 0) return 0;
    return (num * 16384) / s;
  endfunction

  // Predict the quaternion for one accepted matrix word.
  function void note_matrix(logic [143:0] d);
    longint a[9];
    longint tr, r, root, s, qt;
    longint q[4];
    rmq_pkg::sel_t sel;
    quat_t e;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(d[16*i +: 16]));
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      sel = rmq_pkg::SEL_TRACE; r = 16384 + tr;
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      sel = rmq_pkg::SEL_X; r = 16384 + a[0] - a[4] - a[8];
    end else if (a[4] > a[8]) begin
      sel = rmq_pkg::SEL_Y; r = 16384 + a[4] - a[0] - a[8];
    end else begin
      sel = rmq_pkg::SEL_Z; r = 16384 + a[8] - a[0] - a[4];
    end
    e = '0;
    if (r <= 0) begin
      e.bad = 1'b1;
    end else begin
      root = isqrt(r <<< 14);
      s = root * 2;
      qt = root >>> 1;
      case (sel)
        rmq_pkg::SEL_TRACE: begin
          q[0] = qt; q[1] = quo(a[7] - a[5], s);
          q[2] = quo(a[2] - a[6], s); q[3] = quo(a[3] - a[1], s);
        end
        rmq_pkg::SEL_X: begin
          q[0] = quo(a[7] - a[5], s); q[1] = qt;
          q[2] = quo(a[1] + a[3], s); q[3] = quo(a[2] + a[6], s);
        end
        rmq_pkg::SEL_Y: begin
          q[0] = quo(a[2] - a[6], s); q[1] = quo(a[1] + a[3], s);
          q[2] = qt; q[3] = quo(a[5] + a[7], s);
        end
        default: begin
          q[0] = quo(a[3] - a[1], s); q[1] = quo(a[2] + a[6], s);
          q[2] = quo(a[5] + a[7], s); q[3] = qt;
        end
      endcase
      e.qw = clip16(q[0]); e.qx = clip16(q[1]);
      e.qy = clip16(q[2]); e.qz = clip16(q[3]);
    end
    pending.push_back(e);
  endfunction

  // Compare one accepted quaternion word with the oldest prediction.
  function void check_quat(logic [63:0] d, logic bad);
    quat_t e, got;
    got.qw = d[15:0]; got.qx = d[31:16]; got.qy = d[47:32]; got.qz = d[63:48];
    got.bad = bad;
    if (pending.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("unexpected word %h invalid %b", d, bad);
      end
      return;
    end
    e = pending.pop_front();
    if (got !== e) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("mismatch exp w %h x %h y %h z %h inv %b / got w %h x %h y %h z %h inv %b",
                 e.qw, e.qx, e.qy, e.qz, e.bad, got.qw, got.qx, got.qy, got.qz, got.bad);
      end
    end
  endfunction
endclass

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int LATENCY = 35;
  localparam int IDLE_LIMIT = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // qw, qx, qy, qz (16 bits each, lowest first)
  logic [63:0]  out_tdata;
  // invalid
  logic         out_tuser;

  quat_scoreboard sb;
  bit  calm;          // no random idling on either side while set; the receiver's hold-off still applies
  int  idle_cycles;

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample both channels at the rising edge; keep the watchdog here too.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_matrix(in_tdata);
      if (out_tvalid && out_tready) sb.check_quat(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one matrix word and hold it until accepted; optionally idle first.
  task automatic send_matrix(logic [143:0] m);
    if (!calm && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [143:0] pack9(int e[9]);
    logic [143:0] m;
    for (int i = 0; i < 9; i++) m[16*i +: 16] = 16'(e[i]);
    return m;
  endfunction

  // Random value biased toward the edges of the Q2.14 range.
  function automatic int pick_elem();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return $urandom_range(32767);
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // Well-formed rotation about an axis, perturbed a little, with a random case.
  function automatic logic [143:0] rand_rotation();
    int e[9];
    real c, s, ang;
    int k;
    ang = ($urandom_range(62831) / 10000.0);
    c = $cos(ang); s = $sin(ang);
    k = $urandom_range(2);
    for (int i = 0; i < 9; i++) e[i] = 0;
    e[4*k] = 16384;
    e[(4*((k+1)%3))] = int'(c * 16384);
    e[(4*((k+2)%3))] = int'(c * 16384);
    e[3*((k+1)%3) + (k+2)%3] = int'(-s * 16384);
    e[3*((k+2)%3) + (k+1)%3] = int'(s * 16384);
    for (int i = 0; i < 9; i++) e[i] += $urandom_range(8) - 4;
    return pack9(e);
  endfunction

  // Receiver: random stalls, calm stretches, and one long hold-off while the
  // sender is still offering words.
  initial begin
    int cyc;
    out_tready = 1'b0;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 400 && cyc < 600) out_tready <= 1'b0;
      else if (calm) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(99) >= 15);
    end
  end

  initial begin
    int e[9];
    int t;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    calm = 1'b0;
    idle_cycles = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: identity, each dominant diagonal, ties, extremes.
    e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};   send_matrix(pack9(e));
    e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(pack9(e));
    e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(pack9(e));
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(pack9(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};               send_matrix(pack9(e));
    e = '{-8192, 1, 2, 3, -8192, 4, 5, 6, -8192};   send_matrix(pack9(e));
    e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_matrix(pack9(e));
    e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_matrix(pack9(e));
    e = '{1, -32768, 32767, 32767, 1, -32768, -32768, 32767, -2};
    send_matrix(pack9(e));
    e = '{-20000, 32767, -32768, 32767, -20000, 32767, -32768, 32767, -30000};
    send_matrix(pack9(e));
    e = '{-16384, 32767, 32767, 32767, -32768, -32768, 32767, -32768, -32768};
    send_matrix(pack9(e));
    e = '{-32768, -32768, -32768, -32768, 0, -32768, -32768, -32768, -32768};
    send_matrix(pack9(e));
    e = '{-1, 100, -100, 100, -1, -100, 100, -100, -1};  send_matrix(pack9(e));
    e = '{-16385, 5, 5, 5, -16385, 5, 5, 5, 16384};      send_matrix(pack9(e));

    for (int n = 0; n < 450; n++) begin
      if (n == 150) calm = 1'b1;
      if (n == 230) calm = 1'b0;
      if ($urandom_range(99) < 65) begin
        send_matrix(rand_rotation());
      end else begin
        for (int i = 0; i < 9; i++) e[i] = pick_elem();
        send_matrix(pack9(e));
      end
    end
    in_tvalid <= 1'b0;

    t = 0;
    while (sb.pending.size() != 0 && t < 20000) begin
      @(negedge clk);
      t++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
